/* hdl/vftc_pkg.sv */
// ----------------------------------------------------------------------------
// vftc_pkg
// transaction types and operation/status codes for the value frequency
// threshold counter
// ----------------------------------------------------------------------------
package vftc_pkg;

  localparam int FUNC_W      = 2;
  localparam int COLOR_W     = 10;
  localparam int THRESHOLD_W = 10;
  localparam int ANSWER_W    = 11;
  localparam int STATUS_W    = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [COLOR_W-1:0]     color;
    logic [THRESHOLD_W-1:0] threshold;
  } req_t;

  typedef struct packed {
    logic [ANSWER_W-1:0] answer;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

/* hdl/value_frequency_threshold_counter.sv */
// ----------------------------------------------------------------------------
// value_frequency_threshold_counter
// multiset of colour values with a count-of-counts fenwick tree; answers how
// many colours occur at least a given number of times
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass of max(NUM_COLORS, MAX_COUNT+1)
// addresses (1024 at the defaults) over the per-colour count memory and the
// tree memory, with req_stall high. Then one transaction is worked at a time.
// An add or remove reads the colour's count, then walks the tree upward from
// the old count (decrement) and from the new count (increment), one tree
// entry per cycle: the tree memory writes the current entry and reads the
// next one in the same cycle. A query walks the prefix sum down from
// MAX_COUNT and again from threshold-1, one entry per cycle. Each walk
// visits at most ceil(log2(MAX_COUNT+1)) entries, and the two walks of one
// item visit at most 19 entries together at the defaults, so the longest
// item is an add or remove between counts one and two and the shortest a
// spare func code, the tree walks being what sets the length.
// On top of that an item waits in the done state for as long as the output
// register is full and stalled. A finished result sits in an output
// register; the next request is accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module value_frequency_threshold_counter #(
  parameter int NUM_COLORS = 1024,
  parameter int MAX_COUNT  = 1023
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  vftc_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output vftc_pkg::rsp_t   rsp
);

  // colour index, count and tree entry widths
  localparam int CW = $clog2(NUM_COLORS);
  localparam int KW = $clog2(MAX_COUNT + 1);
  localparam int TW = $clog2(NUM_COLORS + 1);
  // accumulator at least as wide as the answer field
  localparam int AW = (TW > vftc_pkg::ANSWER_W) ? TW : vftc_pkg::ANSWER_W;
  // clearing pass covers the larger memory
  localparam int CLR_LEN = (NUM_COLORS > MAX_COUNT + 1) ? NUM_COLORS : MAX_COUNT + 1;
  localparam int LW = $clog2(CLR_LEN);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CREAD = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_INC   = 3'd4;
  localparam logic [2:0] S_QTOT  = 3'd5;
  localparam logic [2:0] S_QLOW  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state, state_next;
  logic [LW-1:0] clr, clr_next;
  logic [vftc_pkg::FUNC_W-1:0] func, func_next;
  logic [CW-1:0] cidx, cidx_next;
  logic [KW-1:0] kpos, kpos_next;
  logic [KW-1:0] c_new, c_new_next;
  logic [KW-1:0] pos, pos_next;
  logic [AW-1:0] acc, acc_next;
  logic [AW-1:0] total, total_next;
  vftc_pkg::rsp_t res, res_next;

  // memory ports
  logic          cmem_we;
  logic [CW-1:0] cmem_waddr, cmem_raddr;
  logic [KW-1:0] cmem_wdata, cmem_rdata;
  logic          tmem_we;
  logic [KW-1:0] tmem_waddr, tmem_raddr;
  logic [TW-1:0] tmem_wdata, tmem_rdata;

  // walk arithmetic
  logic [KW-1:0] lb;
  logic [KW:0]   up;
  logic [KW-1:0] dn;
  logic [AW-1:0] acc_sum;
  logic [AW-1:0] diff;
  logic [KW-1:0] c_old, c_step;
  logic [vftc_pkg::THRESHOLD_W-1:0] k;
  logic          out_free;

  vftc_ram #(
    .DEPTH  (NUM_COLORS),
    .ADDR_W (CW),
    .DATA_W (KW)
  ) u_count_mem (
    .clk   (clk),
    .we    (cmem_we),
    .waddr (cmem_waddr),
    .wdata (cmem_wdata),
    .raddr (cmem_raddr),
    .rdata (cmem_rdata)
  );

  vftc_ram #(
    .DEPTH  (MAX_COUNT + 1),
    .ADDR_W (KW),
    .DATA_W (TW)
  ) u_tree_mem (
    .clk   (clk),
    .we    (tmem_we),
    .waddr (tmem_waddr),
    .wdata (tmem_wdata),
    .raddr (tmem_raddr),
    .rdata (tmem_rdata)
  );

  // lowest set bit of the tree position, and the neighbors it leads to
  assign lb      = pos & (~pos + {{(KW-1){1'b0}}, 1'b1});
  assign up      = {1'b0, pos} + {1'b0, lb};
  assign dn      = pos - lb;
  assign acc_sum = acc + AW'(tmem_rdata);
  assign diff    = total - acc_sum;
  assign c_old   = cmem_rdata;
  assign k       = (req.threshold == '0) ? vftc_pkg::THRESHOLD_W'(1) : req.threshold;

  // output slot can take a result this cycle
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    // count after the move, used only when the move is legal
    if (func == vftc_pkg::FUNC_ADD) begin
      c_step = c_old + KW'(1);
    end else begin
      c_step = c_old - KW'(1);
    end
  end

  always_comb begin
    state_next = state;
    clr_next   = clr;
    func_next  = func;
    cidx_next  = cidx;
    kpos_next  = kpos;
    c_new_next = c_new;
    pos_next   = pos;
    acc_next   = acc;
    total_next = total;
    res_next   = res;

    cmem_we    = 1'b0;
    cmem_waddr = cidx;
    cmem_wdata = c_new;
    cmem_raddr = cidx;
    tmem_we    = 1'b0;
    tmem_waddr = pos;
    tmem_wdata = tmem_rdata;
    tmem_raddr = pos;

    case (state)
      S_CLEAR: begin
        // zero both memories, one entry of each per cycle
        cmem_we    = ({1'b0, clr} < (LW+1)'(NUM_COLORS));
        cmem_waddr = CW'(clr);
        cmem_wdata = '0;
        tmem_we    = ({1'b0, clr} < (LW+1)'(MAX_COUNT + 1));
        tmem_waddr = KW'(clr);
        tmem_wdata = '0;
        clr_next   = clr + LW'(1);
        if (clr == LW'(CLR_LEN - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          func_next = req.func;
          cidx_next = CW'(req.color);
          res_next  = '{answer: '0, status: vftc_pkg::STATUS_OK};
          case (req.func)
            vftc_pkg::FUNC_ADD, vftc_pkg::FUNC_REMOVE: begin
              // colours beyond the table are ignored
              if (17'(req.color) < 17'(NUM_COLORS)) begin
                cmem_raddr = CW'(req.color);
                state_next = S_CREAD;
              end else begin
                state_next = S_DONE;
              end
            end
            vftc_pkg::FUNC_QUERY: begin
              if (17'(k) <= 17'(MAX_COUNT)) begin
                kpos_next  = KW'(k - vftc_pkg::THRESHOLD_W'(1));
                pos_next   = KW'(MAX_COUNT);
                tmem_raddr = KW'(MAX_COUNT);
                acc_next   = '0;
                state_next = S_QTOT;
              end else begin
                state_next = S_DONE;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_CREAD: begin
        if ((func == vftc_pkg::FUNC_ADD) && (c_old >= KW'(MAX_COUNT))) begin
          res_next.status = vftc_pkg::STATUS_FULL;
          state_next      = S_DONE;
        end else if ((func == vftc_pkg::FUNC_REMOVE) && (c_old == '0)) begin
          res_next.status = vftc_pkg::STATUS_ABSENT;
          state_next      = S_DONE;
        end else begin
          cmem_we    = 1'b1;
          cmem_wdata = c_step;
          c_new_next = c_step;
          if (c_old != '0) begin
            pos_next   = c_old;
            tmem_raddr = c_old;
            state_next = S_DEC;
          end else begin
            pos_next   = c_step;
            tmem_raddr = c_step;
            state_next = S_INC;
          end
        end
      end

      S_DEC: begin
        // one fewer colour at the old count
        tmem_we    = 1'b1;
        tmem_wdata = tmem_rdata - TW'(1);
        if (up <= (KW+1)'(MAX_COUNT)) begin
          pos_next   = up[KW-1:0];
          tmem_raddr = up[KW-1:0];
        end else if (c_new != '0) begin
          pos_next   = c_new;
          tmem_raddr = c_new;
          state_next = S_INC;
        end else begin
          state_next = S_DONE;
        end
      end

      S_INC: begin
        // one more colour at the new count
        tmem_we    = 1'b1;
        tmem_wdata = tmem_rdata + TW'(1);
        if (up <= (KW+1)'(MAX_COUNT)) begin
          pos_next   = up[KW-1:0];
          tmem_raddr = up[KW-1:0];
        end else begin
          state_next = S_DONE;
        end
      end

      S_QTOT: begin
        // prefix sum over all counts: colours present
        acc_next = acc_sum;
        if (dn != '0) begin
          pos_next   = dn;
          tmem_raddr = dn;
        end else begin
          total_next = acc_sum;
          if (kpos == '0) begin
            res_next.answer = acc_sum[vftc_pkg::ANSWER_W-1:0];
            state_next      = S_DONE;
          end else begin
            pos_next   = kpos;
            tmem_raddr = kpos;
            acc_next   = '0;
            state_next = S_QLOW;
          end
        end
      end

      S_QLOW: begin
        // prefix sum below the threshold
        acc_next = acc_sum;
        if (dn != '0) begin
          pos_next   = dn;
          tmem_raddr = dn;
        end else begin
          res_next.answer = diff[vftc_pkg::ANSWER_W-1:0];
          state_next      = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk) begin
    func  <= func_next;
    cidx  <= cidx_next;
    kpos  <= kpos_next;
    c_new <= c_new_next;
    pos   <= pos_next;
    acc   <= acc_next;
    total <= total_next;
    res   <= res_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      rsp <= res;
    end
  end

endmodule

/* hdl/vftc_ram.sv */
// ----------------------------------------------------------------------------
// vftc_ram
// simple dual-port synchronous memory, one write and one registered read per
// cycle; a read of the address written in the same cycle returns the new data
// ----------------------------------------------------------------------------
module vftc_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first bypass for same-cycle access to one entry
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* tb/vftc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vftc_checker
// Watches the request and response channels of the frequency threshold
// counter. It keeps its own colour counts and a histogram of counts, works
// out the response of each accepted request, and compares each accepted
// response with the oldest one still pending.
// ----------------------------------------------------------------------------
module vftc_checker #(
  parameter int NUM_COLORS = 1024,
  parameter int MAX_COUNT  = 1023
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  vftc_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  vftc_pkg::rsp_t rsp,
  output int             errors,
  output int             outstanding
);

  int unsigned    colour_tally [NUM_COLORS];
  // how many colours currently sit at each count
  int unsigned    count_hist [MAX_COUNT+1];
  vftc_pkg::rsp_t pending_answers [$];

  function automatic vftc_pkg::rsp_t apply_to_multiset(input vftc_pkg::req_t t);
    vftc_pkg::rsp_t r;
    int unsigned    c;
    int unsigned    k;
    int unsigned    total;
    r.answer = '0;
    r.status = vftc_pkg::STATUS_OK;
    case (t.func)
      vftc_pkg::FUNC_ADD, vftc_pkg::FUNC_REMOVE: begin
        if (t.color < NUM_COLORS) begin
          c = colour_tally[t.color];
          if (t.func == vftc_pkg::FUNC_ADD && c >= MAX_COUNT) begin
            r.status = vftc_pkg::STATUS_FULL;
          end else if (t.func == vftc_pkg::FUNC_REMOVE && c == 0) begin
            r.status = vftc_pkg::STATUS_ABSENT;
          end else begin
            count_hist[c]--;
            c = (t.func == vftc_pkg::FUNC_ADD) ? c + 1 : c - 1;
            count_hist[c]++;
            colour_tally[t.color] = c;
          end
        end
      end
      vftc_pkg::FUNC_QUERY: begin
        k = (t.threshold == 0) ? 1 : t.threshold;
        total = 0;
        for (int n = k; n <= MAX_COUNT; n++) total += count_hist[n];
        r.answer = total[vftc_pkg::ANSWER_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    vftc_pkg::rsp_t want;
    if (rst) begin
      foreach (colour_tally[i]) colour_tally[i] = 0;
      foreach (count_hist[i]) count_hist[i] = 0;
      count_hist[0] = NUM_COLORS;
      pending_answers.delete();
      errors = 0;
    end else begin
      // compare first so a stray response never meets this edge's request
      if (rsp_valid && !rsp_stall) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected response answer=%0d status=%0d",
                   $time, rsp.answer, rsp.status);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (rsp.answer !== want.answer) begin
            $display("%0t: answer mismatch expected=%0d actual=%0d",
                     $time, want.answer, rsp.answer);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status mismatch expected=%0d actual=%0d",
                     $time, want.status, rsp.status);
            errors++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        pending_answers.insert(pending_answers.size(), apply_to_multiset(req));
      end
    end
    outstanding = pending_answers.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the value frequency threshold counter. A short
// directed run covers the corner cases, one colour is then pumped to its
// maximum count, and a random mix of adds, removes and queries follows,
// with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_COLORS = 1024;
  localparam int MAX_COUNT  = 1023;
  // the spare func code; the block must answer it with zeros
  localparam logic [vftc_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_ITEMS  = 150;
  localparam int LONG_HOLD    = 300;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  vftc_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_stall;
  vftc_pkg::rsp_t rsp;
  int             errors;
  int             outstanding;

  // written by the sender; quiet and hold_output are also read by the receiver process
  logic quiet;
  logic hold_output;
  logic [vftc_pkg::COLOR_W-1:0] hot_colour [8];

  value_frequency_threshold_counter #(
    .NUM_COLORS(NUM_COLORS),
    .MAX_COUNT (MAX_COUNT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  vftc_checker #(
    .NUM_COLORS(NUM_COLORS),
    .MAX_COUNT (MAX_COUNT)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .errors     (errors),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard limit: the slowest correct run is well under a fifth of this,
  // clearing pass and long hold included
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // offer one transaction and hold it until the block takes it
  task automatic offer(input vftc_pkg::req_t t);
    req_valid <= 1'b1;
    req       <= t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // random gap on the request side after an accepted transaction
  task automatic request_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send(input vftc_pkg::req_t t);
    offer(t);
    request_gap();
  endtask

  function automatic vftc_pkg::req_t make_req(input logic [vftc_pkg::FUNC_W-1:0] f,
                                              input int c, input int k);
    vftc_pkg::req_t t;
    t.func      = f;
    t.color     = c[vftc_pkg::COLOR_W-1:0];
    t.threshold = k[vftc_pkg::THRESHOLD_W-1:0];
    return t;
  endfunction

  // mostly a few hot colours so counts climb and removes find something,
  // the rest spread over the whole colour range
  function automatic vftc_pkg::req_t random_req(input int pumped_colour);
    vftc_pkg::req_t t;
    int             pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      t.func = vftc_pkg::FUNC_ADD;
    else if (pick < 70) t.func = vftc_pkg::FUNC_REMOVE;
    else if (pick < 95) t.func = vftc_pkg::FUNC_QUERY;
    else                t.func = FUNC_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 10)      t.color = pumped_colour[vftc_pkg::COLOR_W-1:0];
    else if (pick < 65) t.color = hot_colour[$urandom_range(0, 7)];
    else t.color = vftc_pkg::COLOR_W'($urandom_range(0, NUM_COLORS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 50)      t.threshold = vftc_pkg::THRESHOLD_W'($urandom_range(0, 6));
    else if (pick < 80) t.threshold = vftc_pkg::THRESHOLD_W'($urandom_range(0, 63));
    else                t.threshold = vftc_pkg::THRESHOLD_W'($urandom_range(0, 1023));
    return t;
  endfunction

  // response side: random stall bursts, plus one long hold on request
  initial begin
    bit held;
    held = 1'b0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output && !held) begin
        // long hold so the block fills and stalls its input
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    int pumped;
    quiet       = 1'b0;
    hold_output = 1'b0;
    req_valid  <= 1'b0;
    req        <= '0;
    rst        <= 1'b1;
    foreach (hot_colour[i]) begin
      hot_colour[i] = vftc_pkg::COLOR_W'($urandom_range(0, NUM_COLORS - 1));
    end
    pumped = $urandom_range(0, NUM_COLORS - 1);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed corners: empty queries, absent removes, extreme colours
    // and thresholds, the spare func code
    send(make_req(vftc_pkg::FUNC_QUERY,  0,     0));
    send(make_req(vftc_pkg::FUNC_REMOVE, 0,     1023));
    send(make_req(vftc_pkg::FUNC_ADD,    0,     0));
    send(make_req(vftc_pkg::FUNC_ADD,    1023,  1023));
    send(make_req(vftc_pkg::FUNC_ADD,    1023,  0));
    send(make_req(vftc_pkg::FUNC_QUERY,  1023,  0));
    send(make_req(vftc_pkg::FUNC_QUERY,  0,     1));
    send(make_req(vftc_pkg::FUNC_QUERY,  0,     2));
    send(make_req(vftc_pkg::FUNC_QUERY,  0,     1023));
    send(make_req(FUNC_UNUSED,           1023,  1023));
    send(make_req(vftc_pkg::FUNC_REMOVE, 1023,  0));
    send(make_req(vftc_pkg::FUNC_REMOVE, 1023,  0));
    send(make_req(vftc_pkg::FUNC_REMOVE, 1023,  0));
    send(make_req(vftc_pkg::FUNC_ADD,    'h2AA, 'h155));
    send(make_req(vftc_pkg::FUNC_ADD,    'h155, 'h2AA));
    send(make_req(vftc_pkg::FUNC_QUERY,  0,     1));
    send(make_req(vftc_pkg::FUNC_REMOVE, 0,     0));
    send(make_req(FUNC_UNUSED,           0,     0));

    // pump one colour to the maximum count; the long output hold lands
    // at the start of this stretch
    hold_output = 1'b1;
    for (int n = 1; n <= MAX_COUNT; n++) begin
      send(make_req(vftc_pkg::FUNC_ADD, pumped, $urandom_range(0, 1023)));
      if (n % 64 == 0) send(make_req(vftc_pkg::FUNC_QUERY, $urandom_range(0, 1023), n));
    end
    // adds at the maximum are refused
    send(make_req(vftc_pkg::FUNC_ADD,    pumped, 0));
    send(make_req(vftc_pkg::FUNC_ADD,    pumped, 0));
    send(make_req(vftc_pkg::FUNC_QUERY,  pumped, MAX_COUNT));
    send(make_req(vftc_pkg::FUNC_QUERY,  pumped, MAX_COUNT - 1));
    send(make_req(vftc_pkg::FUNC_REMOVE, pumped, 0));
    send(make_req(vftc_pkg::FUNC_QUERY,  pumped, MAX_COUNT));
    send(make_req(vftc_pkg::FUNC_ADD,    pumped, 0));
    send(make_req(vftc_pkg::FUNC_QUERY,  pumped, MAX_COUNT));

    // random mix; the tail runs with no idling on either side
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send(random_req(pumped));
    end
    req_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    // allow for a late stray response
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
